>>> rtl/tit_pkg.sv
`default_nettype none

package tit_pkg;

    localparam int CALLER_ENTRIES = 8;
    localparam int SOURCE_COUNT   = 2;

    localparam int ENT_W = (CALLER_ENTRIES > 1) ? $clog2(CALLER_ENTRIES) : 1;
    localparam int SRC_W = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = CFG_IDX_W'(1);

    localparam logic [31:0] DEFAULT_INTERVAL = 32'd5000;

    localparam logic REC_STATS = 1'b0;
    localparam logic REC_ENTRY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_ACCUM,
        ST_SCAN,
        ST_COMMIT,
        ST_FCHK,
        ST_STAT,
        ST_ENTRY,
        ST_LAST
    } tit_state_t;

    typedef struct packed {
        logic clear_all;
        logic clear_src;
        logic delta_en;
        logic accum_en;
    } tit_stats_ctl_t;

    typedef struct packed {
        logic clear_all;
        logic clear_src;
        logic scan_en;
        logic scan_first;
        logic commit;
    } tit_tbl_ctl_t;

    typedef struct packed {
        logic        record_type;
        logic        report_source;
        logic [31:0] delta_count;
        logic [63:0] delta_total;
        logic [31:0] delta_min;
        logic [31:0] delta_max;
        logic [63:0] entry_address;
        logic [31:0] entry_calls;
    } tit_report_t;

endpackage

`default_nettype wire

>>> rtl/tit_stats.sv
`default_nettype none

module tit_stats
    import tit_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tit_stats_ctl_t ctl,
    input  wire logic [SRC_W-1:0] src,
    input  wire logic [63:0]    now,
    output logic [31:0]         tally,
    output logic [63:0]         total,
    output logic [31:0]         dmin,
    output logic [31:0]         dmax
);

    logic [63:0] stamp_reg    [SOURCE_COUNT];
    logic        stamp_ok_reg [SOURCE_COUNT];
    logic [31:0] tally_reg    [SOURCE_COUNT];
    logic [63:0] sum_reg      [SOURCE_COUNT];
    logic [31:0] min_reg      [SOURCE_COUNT];
    logic [31:0] max_reg      [SOURCE_COUNT];

    logic [31:0] delta_reg;
    logic        delta_ok_reg;

    logic [64:0] diff;
    logic [64:0] sum_ext;

    assign diff    = {1'b0, now} - {1'b0, stamp_reg[src]};
    assign sum_ext = {1'b0, sum_reg[src]} + {33'b0, delta_reg};

    assign tally = tally_reg[src];
    assign total = sum_reg[src];
    assign dmin  = min_reg[src];
    assign dmax  = max_reg[src];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg    <= '0;
            delta_ok_reg <= 1'b0;
            for (int i = 0; i < SOURCE_COUNT; i++)
            begin
                stamp_reg[i]    <= '0;
                stamp_ok_reg[i] <= 1'b0;
                tally_reg[i]    <= '0;
                sum_reg[i]      <= '0;
                min_reg[i]      <= '0;
                max_reg[i]      <= '0;
            end
        end
        else if (ctl.clear_all)
        begin
            delta_ok_reg <= 1'b0;
            for (int i = 0; i < SOURCE_COUNT; i++)
            begin
                stamp_reg[i]    <= '0;
                stamp_ok_reg[i] <= 1'b0;
                tally_reg[i]    <= '0;
                sum_reg[i]      <= '0;
                min_reg[i]      <= '0;
                max_reg[i]      <= '0;
            end
        end
        else
        begin
            if (ctl.delta_en)
            begin
                delta_reg    <= diff[31:0];
                delta_ok_reg <= stamp_ok_reg[src] && !diff[64];
            end
            if (ctl.accum_en)
            begin
                stamp_reg[src]    <= now;
                stamp_ok_reg[src] <= 1'b1;
                if (delta_ok_reg)
                begin
                    sum_reg[src] <= sum_ext[64] ? '1 : sum_ext[63:0];
                    if (tally_reg[src] != '1)
                        tally_reg[src] <= tally_reg[src] + 32'd1;
                    if (tally_reg[src] == '0 || delta_reg < min_reg[src])
                        min_reg[src] <= delta_reg;
                    if (delta_reg > max_reg[src])
                        max_reg[src] <= delta_reg;
                end
                delta_ok_reg <= 1'b0;
            end
            if (ctl.clear_src)
            begin
                tally_reg[src] <= '0;
                sum_reg[src]   <= '0;
                min_reg[src]   <= '0;
                max_reg[src]   <= '0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/tit_callers.sv
`default_nettype none

module tit_callers
    import tit_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tit_tbl_ctl_t     ctl,
    input  wire logic [SRC_W-1:0] src,
    input  wire logic [ENT_W-1:0] idx,
    input  wire logic [63:0]      who,
    output logic [63:0]           rd_addr,
    output logic [31:0]           rd_calls
);

    logic [63:0] addr_reg  [SOURCE_COUNT][CALLER_ENTRIES];
    logic [31:0] calls_reg [SOURCE_COUNT][CALLER_ENTRIES];

    logic             match_found_reg;
    logic [ENT_W-1:0] match_idx_reg;
    logic             empty_found_reg;
    logic [ENT_W-1:0] empty_idx_reg;
    logic [ENT_W-1:0] low_idx_reg;
    logic [31:0]      low_calls_reg;

    logic        hit;
    logic        empty;
    logic [31:0] match_calls;

    assign rd_addr     = addr_reg[src][idx];
    assign rd_calls    = calls_reg[src][idx];
    assign hit         = (rd_addr == who);
    assign empty       = (rd_calls == '0);
    assign match_calls = calls_reg[src][match_idx_reg];

    // scan trackers: first match, first empty slot, first smallest count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            low_idx_reg     <= '0;
            low_calls_reg   <= '0;
        end
        else if (ctl.scan_en)
        begin
            if (ctl.scan_first)
            begin
                match_found_reg <= hit;
                match_idx_reg   <= idx;
                empty_found_reg <= empty;
                empty_idx_reg   <= idx;
                low_idx_reg     <= idx;
                low_calls_reg   <= rd_calls;
            end
            else
            begin
                if (!match_found_reg && hit)
                begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= idx;
                end
                if (!empty_found_reg && empty)
                begin
                    empty_found_reg <= 1'b1;
                    empty_idx_reg   <= idx;
                end
                if (rd_calls < low_calls_reg)
                begin
                    low_idx_reg   <= idx;
                    low_calls_reg <= rd_calls;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SOURCE_COUNT; s++)
                for (int e = 0; e < CALLER_ENTRIES; e++)
                begin
                    addr_reg[s][e]  <= '0;
                    calls_reg[s][e] <= '0;
                end
        end
        else if (ctl.clear_all)
        begin
            for (int s = 0; s < SOURCE_COUNT; s++)
                for (int e = 0; e < CALLER_ENTRIES; e++)
                begin
                    addr_reg[s][e]  <= '0;
                    calls_reg[s][e] <= '0;
                end
        end
        else if (ctl.clear_src)
        begin
            for (int e = 0; e < CALLER_ENTRIES; e++)
            begin
                addr_reg[src][e]  <= '0;
                calls_reg[src][e] <= '0;
            end
        end
        else if (ctl.commit)
        begin
            if (match_found_reg)
            begin
                if (match_calls != '1)
                    calls_reg[src][match_idx_reg] <= match_calls + 32'd1;
            end
            else if (empty_found_reg)
            begin
                addr_reg[src][empty_idx_reg]  <= who;
                calls_reg[src][empty_idx_reg] <= 32'd1;
            end
            else if (low_calls_reg <= 32'd1)
            begin
                addr_reg[src][low_idx_reg]  <= who;
                calls_reg[src][low_idx_reg] <= 32'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/timer_interval_telemetry.sv
`default_nettype none

// Timer interval telemetry.
// Command channel: a sample (source_id, timestamp_ms, caller_address) is taken
// at a clock edge with start high and busy low. busy stays high while the
// sample is processed; a new sample is taken only once busy drops.
// Per sample: ignored when disabled; otherwise a delta step and an accumulate
// step, plus a scan over the CALLER_ENTRIES caller table entries and a commit
// step when the caller is nonzero, plus a flush check step. A flush visits
// each source, walks the caller entries of each reported source, then ends.
// The table scan checks one entry at a time on a single compare unit.
// Reports leave on the result ports, at most one word per cycle marked by
// valid; the receiver cannot stall them. Each word waits in a holding
// register until the next word is generated or the walk ends, so the final
// word carries last_of_flush. Config port: cfg_write with cfg_index/cfg_data,
// taken at once; the user must write only while idle, which the block does
// not enforce. A write to a defined register clears all statistics and
// tables. Reset: disabled, interval 5000, statistics and tables zero.

module timer_interval_telemetry
    import tit_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 source_id,
    input  wire logic [63:0]          timestamp_ms,
    input  wire logic [63:0]          caller_address,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output logic                      valid,
    output logic                      record_type,
    output logic                      report_source,
    output logic [31:0]               delta_count,
    output logic [63:0]               delta_total,
    output logic [31:0]               delta_min,
    output logic [31:0]               delta_max,
    output logic [63:0]               entry_address,
    output logic [31:0]               entry_calls,
    output logic                      last_of_flush
);

    localparam logic [ENT_W-1:0] ENT_LAST = ENT_W'(CALLER_ENTRIES - 1);
    localparam logic [SRC_W-1:0] SRC_LAST = SRC_W'(SOURCE_COUNT - 1);

    tit_state_t state_reg, state_next;

    logic             enable_reg;
    logic [31:0]      interval_reg;
    logic [63:0]      last_flush_reg;
    logic             item_src_reg;
    logic             item_ok_reg;
    logic [63:0]      now_reg;
    logic [63:0]      who_reg;
    logic [SRC_W-1:0] src_cur_reg;
    logic [ENT_W-1:0] idx_reg;
    tit_report_t      held_reg;
    logic             held_valid_reg;
    tit_report_t      out_reg;
    logic             valid_reg;
    logic             last_reg;

    tit_stats_ctl_t   stats_ctl;
    tit_tbl_ctl_t     tbl_ctl;
    logic             cfg_hit;
    logic             walking;
    logic [SRC_W-1:0] sel_src;
    logic [64:0]      fdiff;
    logic             flush_hit;
    logic             produce;
    tit_report_t      new_rep;

    logic [31:0] rd_tally;
    logic [63:0] rd_total;
    logic [31:0] rd_min;
    logic [31:0] rd_max;
    logic [63:0] rd_addr;
    logic [31:0] rd_calls;

    assign cfg_hit = cfg_write && (cfg_index == CFG_ENABLE || cfg_index == CFG_INTERVAL);
    assign walking = (state_reg == ST_STAT) || (state_reg == ST_ENTRY);
    assign sel_src = walking ? src_cur_reg : SRC_W'(item_src_reg);

    assign fdiff     = {1'b0, now_reg} - {1'b0, last_flush_reg};
    assign flush_hit = (last_flush_reg == '0) || fdiff[64]
                       || (fdiff[63:0] >= {32'b0, interval_reg});

    tit_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stats_ctl),
        .src   (sel_src),
        .now   (now_reg),
        .tally (rd_tally),
        .total (rd_total),
        .dmin  (rd_min),
        .dmax  (rd_max)
    );

    tit_callers u_callers (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (tbl_ctl),
        .src      (sel_src),
        .idx      (idx_reg),
        .who      (who_reg),
        .rd_addr  (rd_addr),
        .rd_calls (rd_calls)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start && enable_reg) state_next = ST_DELTA;
            ST_DELTA:  state_next = item_ok_reg ? ST_ACCUM : ST_FCHK;
            ST_ACCUM:  state_next = (who_reg != '0) ? ST_SCAN : ST_FCHK;
            ST_SCAN:   if (idx_reg == ENT_LAST) state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_FCHK;
            ST_FCHK:   state_next = flush_hit ? ST_STAT : ST_IDLE;
            ST_STAT:
            begin
                if (rd_tally != '0)
                    state_next = ST_ENTRY;
                else if (src_cur_reg == SRC_LAST)
                    state_next = ST_LAST;
            end
            ST_ENTRY:
            begin
                if (idx_reg == ENT_LAST)
                    state_next = (src_cur_reg == SRC_LAST) ? ST_LAST : ST_STAT;
            end
            ST_LAST:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        stats_ctl           = '0;
        tbl_ctl             = '0;
        stats_ctl.clear_all = cfg_hit;
        tbl_ctl.clear_all   = cfg_hit;
        produce             = 1'b0;
        new_rep             = '0;
        new_rep.report_source = src_cur_reg[0];
        case (state_reg)
            ST_DELTA:  stats_ctl.delta_en = item_ok_reg;
            ST_ACCUM:  stats_ctl.accum_en = 1'b1;
            ST_SCAN:
            begin
                tbl_ctl.scan_en    = 1'b1;
                tbl_ctl.scan_first = (idx_reg == '0);
            end
            ST_COMMIT: tbl_ctl.commit = 1'b1;
            ST_STAT:
            begin
                produce             = (rd_tally != '0);
                new_rep.record_type = REC_STATS;
                new_rep.delta_count = rd_tally;
                new_rep.delta_total = rd_total;
                new_rep.delta_min   = rd_min;
                new_rep.delta_max   = rd_max;
            end
            ST_ENTRY:
            begin
                produce               = (rd_calls != '0);
                new_rep.record_type   = REC_ENTRY;
                new_rep.entry_address = rd_addr;
                new_rep.entry_calls   = rd_calls;
                stats_ctl.clear_src   = (idx_reg == ENT_LAST);
                tbl_ctl.clear_src     = (idx_reg == ENT_LAST);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            enable_reg     <= 1'b0;
            interval_reg   <= DEFAULT_INTERVAL;
            last_flush_reg <= '0;
            item_src_reg   <= 1'b0;
            item_ok_reg    <= 1'b0;
            src_cur_reg    <= '0;
            idx_reg        <= '0;
            held_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;

            if (cfg_hit)
            begin
                last_flush_reg <= '0;
                if (cfg_index == CFG_ENABLE)
                    enable_reg <= cfg_data[0];
                else
                    interval_reg <= (cfg_data == '0) ? DEFAULT_INTERVAL : cfg_data;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        item_src_reg <= source_id;
                        item_ok_reg  <= (32'(source_id) < 32'(SOURCE_COUNT));
                    end
                end
                ST_ACCUM: idx_reg <= '0;
                ST_SCAN:  idx_reg <= (idx_reg == ENT_LAST) ? '0 : idx_reg + ENT_W'(1);
                ST_FCHK:
                begin
                    src_cur_reg <= '0;
                    if (flush_hit)
                        last_flush_reg <= now_reg;
                end
                ST_STAT:
                begin
                    idx_reg <= '0;
                    if (rd_tally == '0 && src_cur_reg != SRC_LAST)
                        src_cur_reg <= src_cur_reg + SRC_W'(1);
                end
                ST_ENTRY:
                begin
                    idx_reg <= (idx_reg == ENT_LAST) ? '0 : idx_reg + ENT_W'(1);
                    if (idx_reg == ENT_LAST && src_cur_reg != SRC_LAST)
                        src_cur_reg <= src_cur_reg + SRC_W'(1);
                end
                ST_LAST:
                begin
                    if (held_valid_reg)
                    begin
                        valid_reg      <= 1'b1;
                        last_reg       <= 1'b1;
                        held_valid_reg <= 1'b0;
                    end
                end
                default: ;
            endcase

            if (produce)
            begin
                held_valid_reg <= 1'b1;
                if (held_valid_reg)
                    valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            now_reg <= timestamp_ms;
            who_reg <= caller_address;
        end
        if (produce)
            held_reg <= new_rep;
        if ((produce || state_reg == ST_LAST) && held_valid_reg)
            out_reg <= held_reg;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign valid         = valid_reg;
    assign last_of_flush = last_reg;
    assign record_type   = out_reg.record_type;
    assign report_source = out_reg.report_source;
    assign delta_count   = out_reg.delta_count;
    assign delta_total   = out_reg.delta_total;
    assign delta_min     = out_reg.delta_min;
    assign delta_max     = out_reg.delta_max;
    assign entry_address = out_reg.entry_address;
    assign entry_calls   = out_reg.entry_calls;

`ifndef ASSERT_OFF
    a_valid_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> ($past(state_reg) == ST_STAT || $past(state_reg) == ST_ENTRY
                   || $past(state_reg) == ST_LAST))
        else $error("report word outside flush walk");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        last_of_flush |-> valid && $past(state_reg) == ST_LAST)
        else $error("last_of_flush without final word");

    a_held_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LAST |=> !held_valid_reg)
        else $error("holding register not drained at end of flush");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !held_valid_reg)
        else $error("pending report while idle");
`endif

endmodule

`default_nettype wire

>>> tb/interval_report_checker.sv
module interval_report_checker
    import tit_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic                 source_id,
    input  wire logic [63:0]          timestamp_ms,
    input  wire logic [63:0]          caller_address,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 valid,
    input  wire logic                 record_type,
    input  wire logic                 report_source,
    input  wire logic [31:0]          delta_count,
    input  wire logic [63:0]          delta_total,
    input  wire logic [31:0]          delta_min,
    input  wire logic [31:0]          delta_max,
    input  wire logic [63:0]          entry_address,
    input  wire logic [31:0]          entry_calls,
    input  wire logic                 last_of_flush,
    output int                        mismatches,
    output int                        pending
);

    typedef struct packed {
        tit_report_t body;
        logic        ends_flush;
    } report_word_t;

    logic        enabled;
    logic [31:0] interval;
    logic [63:0] prev_stamp   [SOURCE_COUNT];
    logic        prev_seen    [SOURCE_COUNT];
    logic [31:0] tally        [SOURCE_COUNT];
    logic [63:0] total        [SOURCE_COUNT];
    logic [31:0] low_delta    [SOURCE_COUNT];
    logic [31:0] high_delta   [SOURCE_COUNT];
    logic [63:0] caller_addr  [SOURCE_COUNT][CALLER_ENTRIES];
    logic [31:0] caller_calls [SOURCE_COUNT][CALLER_ENTRIES];
    logic [63:0] flush_stamp;

    report_word_t expected_words[$];
    int           errors;

    task automatic clear_all();
        flush_stamp = '0;
        for (int src = 0; src < SOURCE_COUNT; src++)
        begin
            prev_stamp[src] = '0;
            prev_seen[src]  = 1'b0;
            tally[src]      = '0;
            total[src]      = '0;
            low_delta[src]  = '0;
            high_delta[src] = '0;
            for (int e = 0; e < CALLER_ENTRIES; e++)
            begin
                caller_addr[src][e]  = '0;
                caller_calls[src][e] = '0;
            end
        end
    endtask

    task automatic predict_sample(input logic s, input logic [63:0] now,
                                  input logic [63:0] who);
        logic [31:0]  d;
        logic [64:0]  sum;
        int           slot;
        bit           hit;
        int           first;
        report_word_t w;
        if (!enabled)
            return;

        if (prev_seen[s] && now >= prev_stamp[s])
        begin
            d   = 32'(now - prev_stamp[s]);
            sum = {1'b0, total[s]} + 65'(d);
            total[s] = sum[64] ? '1 : sum[63:0];
            if (tally[s] == 0 || d < low_delta[s])
                low_delta[s] = d;
            if (d > high_delta[s])
                high_delta[s] = d;
            if (tally[s] != '1)
                tally[s] = tally[s] + 1;
        end
        prev_stamp[s] = now;
        prev_seen[s]  = 1'b1;

        // caller table: bump match, else first free, else weakest entry if count <= 1
        if (who != 0)
        begin
            hit  = 1'b0;
            slot = -1;
            for (int e = 0; e < CALLER_ENTRIES; e++)
                if (!hit && caller_addr[s][e] == who)
                begin
                    hit  = 1'b1;
                    slot = e;
                end
            if (hit)
            begin
                if (caller_calls[s][slot] != '1)
                    caller_calls[s][slot] = caller_calls[s][slot] + 1;
            end
            else
            begin
                for (int e = 0; e < CALLER_ENTRIES; e++)
                    if (slot < 0 && caller_calls[s][e] == 0)
                        slot = e;
                if (slot < 0)
                begin
                    slot = 0;
                    for (int e = 1; e < CALLER_ENTRIES; e++)
                        if (caller_calls[s][e] < caller_calls[s][slot])
                            slot = e;
                    if (caller_calls[s][slot] > 1)
                        slot = -1;
                end
                if (slot >= 0)
                begin
                    caller_addr[s][slot]  = who;
                    caller_calls[s][slot] = 32'd1;
                end
            end
        end

        if (flush_stamp != 0 && now >= flush_stamp &&
            now - flush_stamp < {32'd0, interval})
            return;
        flush_stamp = now;
        first = expected_words.size();
        for (int src = 0; src < SOURCE_COUNT; src++)
        begin
            if (tally[src] != 0)
            begin
                w = '0;
                w.body.record_type   = REC_STATS;
                w.body.report_source = 1'(src);
                w.body.delta_count   = tally[src];
                w.body.delta_total   = total[src];
                w.body.delta_min     = low_delta[src];
                w.body.delta_max     = high_delta[src];
                expected_words.push_back(w);
                for (int e = 0; e < CALLER_ENTRIES; e++)
                    if (caller_calls[src][e] != 0)
                    begin
                        w = '0;
                        w.body.record_type   = REC_ENTRY;
                        w.body.report_source = 1'(src);
                        w.body.entry_address = caller_addr[src][e];
                        w.body.entry_calls   = caller_calls[src][e];
                        expected_words.push_back(w);
                    end
                tally[src]      = '0;
                total[src]      = '0;
                low_delta[src]  = '0;
                high_delta[src] = '0;
                for (int e = 0; e < CALLER_ENTRIES; e++)
                begin
                    caller_addr[src][e]  = '0;
                    caller_calls[src][e] = '0;
                end
            end
        end
        if (expected_words.size() > first)
        begin
            w = expected_words.pop_back();
            w.ends_flush = 1'b1;
            expected_words.push_back(w);
        end
    endtask

    function automatic int field_diff(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        report_word_t w;
        if (!rst_n)
        begin
            enabled  = 1'b0;
            interval = DEFAULT_INTERVAL;
            clear_all();
            expected_words.delete();
            errors = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (valid)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: word expected none got type %0h source %0h addr %0h",
                             $time, record_type, report_source, entry_address);
                    errors++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    errors += field_diff("record_type", 64'(w.body.record_type),
                                         64'(record_type));
                    errors += field_diff("report_source", 64'(w.body.report_source),
                                         64'(report_source));
                    errors += field_diff("delta_count", 64'(w.body.delta_count),
                                         64'(delta_count));
                    errors += field_diff("delta_total", w.body.delta_total, delta_total);
                    errors += field_diff("delta_min", 64'(w.body.delta_min),
                                         64'(delta_min));
                    errors += field_diff("delta_max", 64'(w.body.delta_max),
                                         64'(delta_max));
                    errors += field_diff("entry_address", w.body.entry_address,
                                         entry_address);
                    errors += field_diff("entry_calls", 64'(w.body.entry_calls),
                                         64'(entry_calls));
                    errors += field_diff("last_of_flush", 64'(w.ends_flush),
                                         64'(last_of_flush));
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_ENABLE)
                begin
                    enabled = cfg_data[0];
                    clear_all();
                end
                else if (cfg_index == CFG_INTERVAL)
                begin
                    interval = (cfg_data == 0) ? DEFAULT_INTERVAL : cfg_data;
                    clear_all();
                end
            end
            if (start && !busy)
                predict_sample(source_id, timestamp_ms, caller_address);
            mismatches <= errors;
            pending    <= expected_words.size();
        end
    end

endmodule

>>> tb/testbench.sv
module testbench;
    import tit_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 1000;
    localparam int PHASE_ITEMS   = 55;
    localparam int POOL          = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 start          = 1'b0;
    logic                 source_id      = 1'b0;
    logic [63:0]          timestamp_ms   = '0;
    logic [63:0]          caller_address = '0;
    logic                 cfg_write      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [31:0]          cfg_data       = '0;

    logic        busy;
    logic        valid;
    logic        record_type;
    logic        report_source;
    logic [31:0] delta_count;
    logic [63:0] delta_total;
    logic [31:0] delta_min;
    logic [31:0] delta_max;
    logic [63:0] entry_address;
    logic [31:0] entry_calls;
    logic        last_of_flush;

    int          mismatch_count;
    int          pending_words;
    int          idle_pct;
    logic [63:0] clock_now;
    logic [63:0] callers [POOL];

    timer_interval_telemetry dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .source_id      (source_id),
        .timestamp_ms   (timestamp_ms),
        .caller_address (caller_address),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .valid          (valid),
        .record_type    (record_type),
        .report_source  (report_source),
        .delta_count    (delta_count),
        .delta_total    (delta_total),
        .delta_min      (delta_min),
        .delta_max      (delta_max),
        .entry_address  (entry_address),
        .entry_calls    (entry_calls),
        .last_of_flush  (last_of_flush)
    );

    interval_report_checker report_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .source_id      (source_id),
        .timestamp_ms   (timestamp_ms),
        .caller_address (caller_address),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .valid          (valid),
        .record_type    (record_type),
        .report_source  (report_source),
        .delta_count    (delta_count),
        .delta_total    (delta_total),
        .delta_min      (delta_min),
        .delta_max      (delta_max),
        .entry_address  (entry_address),
        .entry_calls    (entry_calls),
        .last_of_flush  (last_of_flush),
        .mismatches     (mismatch_count),
        .pending        (pending_words)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic send_sample(input logic src, input logic [63:0] stamp,
                               input logic [63:0] who);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        source_id      <= src;
        timestamp_ms   <= stamp;
        caller_address <= who;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_words != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic en, input logic [31:0] period);
        settle();
        write_reg(CFG_INTERVAL, period);
        write_reg(CFG_ENABLE, {31'($urandom), en});
    endtask

    task automatic random_samples(input int count, input int step);
        logic [63:0] stamp;
        logic [63:0] who;
        int          pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                stamp = clock_now + 64'($urandom_range(step));
            else if (pick < 88)
                stamp = clock_now - 64'($urandom_range(4 * step));
            else if (pick < 94)
                stamp = clock_now + {31'd0, 1'b1, 32'($urandom)};
            else
                stamp = {32'($urandom), 32'($urandom)};
            clock_now = stamp;
            pick = $urandom_range(99);
            if (pick < 70)
                who = callers[$urandom_range(POOL - 1)];
            else if (pick < 82)
                who = '0;
            else
                who = {32'($urandom), 32'($urandom)};
            send_sample(1'($urandom_range(1)), stamp, who);
        end
    endtask

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || valid || cfg_write)
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < POOL; i++)
            callers[i] = {32'($urandom), 32'($urandom)} | 64'd1;
        idle_pct  = 25;
        clock_now = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // disabled after reset: ignored
        send_sample(1'b0, 64'd100, callers[0]);
        send_sample(1'b1, 64'd200, callers[1]);

        configure(1'b1, 32'd1);
        send_sample(1'b0, 64'd0, 64'd0);
        send_sample(1'b0, 64'd0, callers[0]);
        send_sample(1'b1, '1, '1);
        send_sample(1'b1, '1, callers[1]);
        send_sample(1'b1, 64'd5, callers[1]);
        send_sample(1'b0, 64'h0000_0000_FFFF_FFFF, callers[0]);
        // undefined register: must not clear history
        settle();
        write_reg(CFG_UNUSED, 32'($urandom));
        send_sample(1'b0, 64'h0000_0001_0000_0002, 64'd0);

        // caller table fill, replacement and drop
        configure(1'b1, '1);
        for (int i = 0; i < CALLER_ENTRIES; i++)
            send_sample(1'b0, 64'd1000 + 64'(i), callers[i]);
        for (int i = 1; i < CALLER_ENTRIES; i++)
            send_sample(1'b0, 64'd1100 + 64'(i), callers[i]);
        send_sample(1'b0, 64'd1200, callers[8]);
        send_sample(1'b0, 64'd1201, callers[8]);
        send_sample(1'b0, 64'd1202, callers[9]);
        send_sample(1'b0, 64'd10, 64'd0);

        configure(1'b1, 32'd1);
        clock_now = '0;
        random_samples(PHASE_ITEMS, 3);
        configure(1'b1, 32'($urandom_range(64, 2)));
        clock_now = {32'd0, 32'($urandom)};
        random_samples(PHASE_ITEMS, 16);
        configure(1'b1, 32'd0);
        clock_now = {32'd0, 32'($urandom)};
        random_samples(PHASE_ITEMS, 400);

        idle_pct = 61;
        configure(1'b1, '1);
        clock_now = {32'($urandom), 32'($urandom)};
        random_samples(PHASE_ITEMS, 50);
        configure(1'b1, 32'($urandom));
        random_samples(PHASE_ITEMS, 1000);
        configure(1'b0, 32'($urandom));
        random_samples(20, 10);

        idle_pct = 0;
        configure(1'b1, 32'd7);
        clock_now = 64'hFFFF_FFFF_FFFF_F000;
        random_samples(PHASE_ITEMS, 8);
        configure(1'b1, 32'd100);
        random_samples(PHASE_ITEMS, 30);
        configure(1'b1, 32'd1);
        random_samples(PHASE_ITEMS, 2);

        settle();
        @(negedge clk);
        if (mismatch_count == 0 && pending_words == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
